/* rtl/stc_pkg.sv */
`default_nettype none
package stc_pkg;
   localparam int TAB_N = 20;
   localparam logic [29:0] EXP_TAB [TAB_N] = '{
      30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
      30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
      30'd1057095000, 30'd1040706261, 30'd1008687096, 30'd947573834, 30'd836230973,
      30'd651257337, 30'd395007542, 30'd145315154, 30'd19666267, 30'd360200
   };
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXP   = 7'b0000010,
      ST_DS    = 7'b0000100,
      ST_DT    = 7'b0001000,
      ST_PROD  = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

/* rtl/stc_if.sv */
`default_nettype none
interface stc_req_if #(parameter int TIME_BITS = 32, parameter int WEIGHT_BITS = 16);
   logic valid;
   logic ready;
   logic train;
   logic [TIME_BITS-1:0] event_time;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic last;
   modport source (output valid, train, event_time, weight, last, input ready);
   modport sink (input valid, train, event_time, weight, last, output ready);
endinterface

interface stc_rsp_if #(parameter int ACC_BITS = 48);
   logic valid;
   logic ready;
   logic signed [ACC_BITS-1:0] correlation;
   logic overflow;
   logic order_error;
   modport source (output valid, correlation, overflow, order_error, input ready);
   modport sink (input valid, correlation, overflow, order_error, output ready);
endinterface
`default_nettype wire

/* rtl/spike_train_correlation.sv */
`default_nettype none
// Zero-lag exponential-kernel inner product of two weighted spike trains, fed as one
// time-ordered event stream (t events before s events at equal times). One shared
// 32x32 multiplier under a sequencer does all work: the decay factor (one step per
// bit of a time step below 2^20), two steps per trace decay and two for the weight
// product (low half, then high half of the trace), one for the accumulate.
// A time step of 2^20 or more skips the bit steps (decay factor zero); the first item
// after reset or a result, and a time that goes backwards, skip the trace decays too.
// req_ready is high again once the accumulate returns to idle, so the next item waits.
// A last item adds a step to load the result register and holds there while an
// earlier result has not been taken yet.
module spike_train_correlation #(
   parameter int TIME_BITS = 32,
   parameter int WEIGHT_BITS = 16,
   parameter int ACC_BITS = 48
) (
   input wire clock,
   input wire reset,
   stc_req_if.sink req,
   stc_rsp_if.source rsp
);
   import stc_pkg::*;
   localparam logic signed [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   state_type state_ff, state_in;
   logic [TIME_BITS-1:0] prev_ff, prev_in, d_ff, d_in;
   logic seen_ff, seen_in, train_ff, train_in, last_ff, last_in;
   logic signed [WEIGHT_BITS-1:0] w_ff, w_in;
   logic signed [ACC_BITS-1:0] ts_ff, ts_in, tt_ff, tt_in, fs_ff, fs_in, bs_ff, bs_in;
   logic signed [ACC_BITS-1:0] prod_ff, prod_in;
   logic [30:0] e_ff, e_in;
   logic [4:0] bit_ff, bit_in;
   logic ph_ff, ph_in;
   logic [63:0] part_ff, part_in;
   logic ovf_ff, ovf_in, oerr_ff, oerr_in;
   logic rv_ff, rv_in;
   logic signed [ACC_BITS-1:0] rc_ff, rc_in;
   logic ro_ff, ro_in, re_ff, re_in;

   // shared multiplier
   logic [31:0] ma;
   logic [31:0] mb;
   logic [63:0] mp;
   assign mp = ma * mb;

   function automatic logic [63:0] mag(input logic signed [ACC_BITS-1:0] v);
      logic [63:0] x;
      x = 64'(v);
      if (v < 0) x = ~x + 64'd1;
      if (v >= 0) x = 64'(v);
      return x;
   endfunction

   function automatic logic signed [ACC_BITS:0] addx(input logic signed [ACC_BITS-1:0] a,
                                                     input logic signed [ACC_BITS-1:0] b);
      return (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
   endfunction

   function automatic logic sat_ovf(input logic signed [ACC_BITS:0] s);
      return s[ACC_BITS] != s[ACC_BITS-1];
   endfunction

   function automatic logic signed [ACC_BITS-1:0] sat_val(input logic signed [ACC_BITS:0] s);
      if (s[ACC_BITS] != s[ACC_BITS-1]) return s[ACC_BITS] ? AMIN : AMAX;
      return s[ACC_BITS-1:0];
   endfunction

   logic signed [ACC_BITS-1:0] dsrc, wtr, trsrc, accsrc, wtrace;
   logic [63:0] dmag, tmag, wmag;
   logic [63:0] lo30, lo12, decayed, wtotal;
   logic [63:0] cap;
   logic neg;
   logic signed [ACC_BITS:0] s1, s2, fin;
   logic signed [ACC_BITS-1:0] half;

   always_comb begin
      dsrc = (state_ff == ST_DS) ? ts_ff : tt_ff;
      dmag = mag(dsrc);
      wtr = ACC_BITS'(w_ff);
      wmag = mag(wtr);
      trsrc = train_ff ? ts_ff : tt_ff;
      tmag = mag(trsrc);
      ma = 32'(e_ff);
      mb = 32'(EXP_TAB[bit_ff]);
      case (state_ff)
         ST_DS, ST_DT: begin
            ma = ph_ff ? dmag[63:32] : dmag[31:0];
            mb = 32'(e_ff);
         end
         ST_PROD: begin
            ma = ph_ff ? tmag[63:32] : tmag[31:0];
            mb = wmag[31:0];
         end
         default: ;
      endcase
      // low half rounded, then high half added on top
      lo30 = 64'((65'(mp) + (65'd1 << 29)) >> 30);
      lo12 = 64'((65'(mp) + 65'd2048) >> 12);
      decayed = (mp << 2) + part_ff;
      wtotal = (mp << 20) + part_ff;
      neg = (w_ff < 0) != (trsrc < 0);
      cap = neg ? 64'(AMAX) + 64'd1 : 64'(AMAX);
      wtrace = ACC_BITS'(w_ff) <<< 12;
      accsrc = train_ff ? bs_ff : fs_ff;
      s1 = addx(accsrc, prod_ff);
      s2 = addx(train_ff ? tt_ff : ts_ff, wtrace);
      fin = addx(fs_ff, bs_ff);
      half = ACC_BITS'(sat_val(fin) >>> 1);
   end

   always_comb begin
      state_in = state_ff;
      prev_in = prev_ff; d_in = d_ff; seen_in = seen_ff;
      train_in = train_ff; last_in = last_ff; w_in = w_ff;
      ts_in = ts_ff; tt_in = tt_ff; fs_in = fs_ff; bs_in = bs_ff;
      prod_in = prod_ff; e_in = e_ff; bit_in = bit_ff;
      ph_in = ph_ff; part_in = part_ff;
      ovf_in = ovf_ff; oerr_in = oerr_ff;
      rv_in = rv_ff; rc_in = rc_ff; ro_in = ro_ff; re_in = re_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               train_in = req.train; last_in = req.last; w_in = req.weight;
               e_in = 31'(1 << 30); bit_in = '0; ph_in = 1'b0;
               d_in = req.event_time - prev_ff;
               state_in = ST_PROD;
               if (!seen_ff) begin
                  prev_in = req.event_time; seen_in = 1'b1;
               end else if (req.event_time < prev_ff) begin
                  oerr_in = 1'b1;
               end else begin
                  prev_in = req.event_time;
                  state_in = ST_EXP;
                  if ((TIME_BITS > 20) &&
                      ((64'(req.event_time - prev_ff) >> 20) != 64'd0)) begin
                     e_in = '0;
                     state_in = ST_DS;
                  end
               end
            end
         end
         ST_EXP: begin
            if (d_ff[bit_ff]) e_in = 31'(lo30);
            if (bit_ff == 5'(TAB_N - 1)) state_in = ST_DS;
            else bit_in = bit_ff + 5'd1;
         end
         ST_DS: begin
            if (!ph_ff) begin
               part_in = lo30; ph_in = 1'b1;
            end else begin
               ts_in = (ts_ff < 0) ? -ACC_BITS'(decayed) : ACC_BITS'(decayed);
               ph_in = 1'b0;
               state_in = ST_DT;
            end
         end
         ST_DT: begin
            if (!ph_ff) begin
               part_in = lo30; ph_in = 1'b1;
            end else begin
               tt_in = (tt_ff < 0) ? -ACC_BITS'(decayed) : ACC_BITS'(decayed);
               ph_in = 1'b0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            if (!ph_ff) begin
               part_in = lo12; ph_in = 1'b1;
            end else begin
               if (wmag == 0 || tmag == 0) prod_in = '0;
               else if (mp > (cap >> 20)) begin
                  ovf_in = 1'b1;
                  prod_in = neg ? AMIN : AMAX;
               end else if (wtotal > cap) begin
                  ovf_in = 1'b1;
                  prod_in = neg ? AMIN : AMAX;
               end else prod_in = neg ? -ACC_BITS'(wtotal) : ACC_BITS'(wtotal);
               ph_in = 1'b0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (train_ff) begin
               bs_in = sat_val(s1); tt_in = sat_val(s2);
            end else begin
               fs_in = sat_val(s1); ts_in = sat_val(s2);
            end
            if (sat_ovf(s1) || sat_ovf(s2)) ovf_in = 1'b1;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1; rc_in = half;
               ro_in = ovf_ff || sat_ovf(fin); re_in = oerr_ff;
               prev_in = '0; seen_in = 1'b0; ts_in = '0; tt_in = '0;
               fs_in = '0; bs_in = '0; ovf_in = 1'b0; oerr_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; prev_ff <= '0; seen_ff <= 1'b0;
         ts_ff <= '0; tt_ff <= '0; fs_ff <= '0; bs_ff <= '0;
         ovf_ff <= 1'b0; oerr_ff <= 1'b0; rv_ff <= 1'b0; ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in; prev_ff <= prev_in; seen_ff <= seen_in;
         ts_ff <= ts_in; tt_ff <= tt_in; fs_ff <= fs_in; bs_ff <= bs_in;
         ovf_ff <= ovf_in; oerr_ff <= oerr_in; rv_ff <= rv_in; ph_ff <= ph_in;
      end
      d_ff <= d_in; train_ff <= train_in; last_ff <= last_in; w_ff <= w_in;
      prod_ff <= prod_in; e_ff <= e_in; bit_ff <= bit_in; part_ff <= part_in;
      rc_ff <= rc_in; ro_ff <= ro_in; re_ff <= re_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.correlation = rc_ff;
   assign rsp.overflow = ro_ff;
   assign rsp.order_error = re_ff;

   a_out_from_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> last_ff) else $error("result without last item");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && (!rv_ff || rsp.ready) |=> !seen_ff && rv_ff)
      else $error("state not cleared");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.correlation))
      else $error("result item changed while waiting");
endmodule
`default_nettype wire
